>>> rtl/core/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg: shared types and helpers for the look-at view matrix pipeline
// Fixed-point format, internal widths, the sideband struct and saturation.
// ----------------------------------------------------------------------------
package lav_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;

  // unit vector component, magnitude up to 1.0
  localparam int UW     = FRAC_BITS + 2;
  // cross product of a unit vector and a word
  localparam int CW     = UW + DW + 1;
  // bit length of a cross magnitude
  localparam int LW     = $clog2(CW + 1);
  // magnitudes are scaled to this many bits before the square sum
  localparam int NORM_W = 30;
  localparam int SQR_W  = 2 * NORM_W;
  localparam int SUM_W  = SQR_W + 2;
  localparam int ROOT_W = NORM_W + 1;
  // quotient bits of a unit component magnitude
  localparam int QB     = FRAC_BITS + 1;
  // camera up after the fractional shift
  localparam int CU_W   = FRAC_BITS + 3;
  // dot products with the eye position
  localparam int DOT_W  = CU_W + DW + 2;
  localparam int SAT_W  = DOT_W + 1;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef logic signed [CW-1:0] wide_t;

  // values that travel alongside the arithmetic
  typedef struct packed {
    word_t [2:0] eye;
    word_t [2:0] up;
    unit_t [2:0] f;
    unit_t [2:0] r;
  } side_t;

  // clamp to the signed word range
  function automatic word_t sat_word(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-DW:0] hi;
    word_t             res;
    hi = x[SAT_W-1:DW-1];
    if (hi == '0 || hi == '1) begin
      res = x[DW-1:0];
    end else if (x[SAT_W-1]) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> rtl/core/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm: pipelined vector normalizer
// Scales the magnitudes to a fixed bit length, takes the integer square root
// of the square sum one bit per stage and divides each magnitude by it, one
// quotient bit per stage. A zero vector comes out as zero.
// ----------------------------------------------------------------------------
module lav_norm (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  lav_pkg::wide_t [2:0]    vec,
  input  lav_pkg::side_t          side_in,
  output logic                    out_valid,
  output lav_pkg::unit_t [2:0]    unit_vec,
  output lav_pkg::side_t          side_out
);

  localparam int NS = lav_pkg::ROOT_W + 3 + lav_pkg::QB;

  typedef struct packed {
    logic [2:0]                           neg;
    logic [2:0][lav_pkg::NORM_W-1:0]      mag;
    lav_pkg::side_t                       side;
  } car_t;

  logic [lav_pkg::CW-1:0]     s1_mag_r [3];
  logic [2:0]                 s1_neg_r;
  lav_pkg::side_t             s1_side_r;
  logic                       s1_v_r;

  logic [lav_pkg::CW-1:0]     s2_mag_r [3];
  logic [2:0]                 s2_neg_r;
  lav_pkg::side_t             s2_side_r;
  logic [lav_pkg::LW-1:0]     s2_len_r;
  logic [lav_pkg::LW-1:0]     len_nxt;
  logic                       s2_v_r;

  car_t                       car_r [NS];
  car_t                       car0_nxt;
  logic [NS-1:0]              v_r;

  logic [lav_pkg::SQR_W-1:0]  sqr_r [3];
  logic [lav_pkg::SUM_W-1:0]  sq_rem_r  [lav_pkg::ROOT_W+1];
  logic [lav_pkg::ROOT_W-1:0] sq_root_r [lav_pkg::ROOT_W+1];

  logic [lav_pkg::ROOT_W-1:0] dv_n_r   [lav_pkg::QB];
  logic [lav_pkg::ROOT_W-1:0] dv_rem_r [lav_pkg::QB][3];
  logic [lav_pkg::QB-1:0]     dv_q_r   [lav_pkg::QB][3];

  lav_pkg::unit_t [2:0]       u_r;
  lav_pkg::side_t             side_r;
  logic                       out_v_r;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg_r[i] <= vec[i][lav_pkg::CW-1];
        s1_mag_r[i] <= vec[i][lav_pkg::CW-1] ? (~vec[i] + 1'b1) : vec[i];
      end
      s1_side_r <= side_in;
    end
  end

  // bit length of the largest magnitude
  always_comb begin
    logic [lav_pkg::CW-1:0] any;
    any = s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
    len_nxt = '0;
    for (int b = 0; b < lav_pkg::CW; b++) begin
      if (any[b]) len_nxt = lav_pkg::LW'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag_r  <= s1_mag_r;
      s2_neg_r  <= s1_neg_r;
      s2_side_r <= s1_side_r;
      s2_len_r  <= len_nxt;
    end
  end

  // scale so the largest magnitude has exactly NORM_W bits
  always_comb begin
    logic [lav_pkg::CW-1:0] sh;
    car0_nxt.neg  = s2_neg_r;
    car0_nxt.side = s2_side_r;
    for (int i = 0; i < 3; i++) begin
      if (s2_len_r > lav_pkg::LW'(lav_pkg::NORM_W)) begin
        sh = s2_mag_r[i] >> (s2_len_r - lav_pkg::LW'(lav_pkg::NORM_W));
      end else begin
        sh = s2_mag_r[i] << (lav_pkg::LW'(lav_pkg::NORM_W) - s2_len_r);
      end
      car0_nxt.mag[i] = sh[lav_pkg::NORM_W-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      v_r     <= {v_r[NS-2:0], s2_v_r};
      out_v_r <= v_r[NS-1];
    end
  end

  // carried magnitudes, signs and sideband
  always_ff @(posedge clk) begin
    if (adv) begin
      car_r[0] <= car0_nxt;
      for (int k = 1; k < NS; k++) car_r[k] <= car_r[k-1];
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) sqr_r[i] <= car_r[0].mag[i] * car_r[0].mag[i];
      sq_rem_r[0]  <= lav_pkg::SUM_W'(sqr_r[0]) + lav_pkg::SUM_W'(sqr_r[1])
                    + lav_pkg::SUM_W'(sqr_r[2]);
      sq_root_r[0] <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < lav_pkg::ROOT_W; k++) begin : g_sqrt
    localparam int BI = lav_pkg::ROOT_W - 1 - k;
    logic [lav_pkg::SUM_W:0]    trial;
    logic [lav_pkg::SUM_W:0]    diff;
    logic [lav_pkg::SUM_W-1:0]  rem_nxt;
    logic [lav_pkg::ROOT_W-1:0] root_nxt;
    always_comb begin
      trial = ((lav_pkg::SUM_W+1)'(sq_root_r[k]) << (BI + 1))
            + ((lav_pkg::SUM_W+1)'(1) << (2 * BI));
      diff  = {1'b0, sq_rem_r[k]} - trial;
      if ({1'b0, sq_rem_r[k]} >= trial) begin
        rem_nxt  = diff[lav_pkg::SUM_W-1:0];
        root_nxt = sq_root_r[k] | (lav_pkg::ROOT_W'(1) << BI);
      end else begin
        rem_nxt  = sq_rem_r[k];
        root_nxt = sq_root_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
      end
    end
  end

  // restoring division of the scaled magnitudes by the root
  for (genvar j = 0; j < lav_pkg::QB; j++) begin : g_div
    logic [lav_pkg::ROOT_W-1:0] n_src;
    logic [lav_pkg::ROOT_W-1:0] rem_src [3];
    logic [lav_pkg::QB-1:0]     q_src   [3];
    logic [2:0]                 bit_src;
    logic [lav_pkg::ROOT_W:0]   sh      [3];
    logic [lav_pkg::ROOT_W:0]   sub     [3];
    logic [lav_pkg::ROOT_W-1:0] rem_nxt [3];
    logic [lav_pkg::QB-1:0]     q_nxt   [3];

    if (j == 0) begin : g_first
      always_comb begin
        n_src = (sq_root_r[lav_pkg::ROOT_W] == '0) ? lav_pkg::ROOT_W'(1)
                                                   : sq_root_r[lav_pkg::ROOT_W];
        for (int i = 0; i < 3; i++) begin
          rem_src[i] = lav_pkg::ROOT_W'(car_r[lav_pkg::ROOT_W+2].mag[i] >> 1);
          q_src[i]   = '0;
          bit_src[i] = car_r[lav_pkg::ROOT_W+2].mag[i][0];
        end
      end
    end else begin : g_next
      always_comb begin
        n_src = dv_n_r[j-1];
        for (int i = 0; i < 3; i++) begin
          rem_src[i] = dv_rem_r[j-1][i];
          q_src[i]   = dv_q_r[j-1][i];
          bit_src[i] = 1'b0;
        end
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i]  = {rem_src[i], bit_src[i]};
        sub[i] = sh[i] - {1'b0, n_src};
        if (sh[i] >= {1'b0, n_src}) begin
          rem_nxt[i] = sub[i][lav_pkg::ROOT_W-1:0];
          q_nxt[i]   = {q_src[i][lav_pkg::QB-2:0], 1'b1};
        end else begin
          rem_nxt[i] = sh[i][lav_pkg::ROOT_W-1:0];
          q_nxt[i]   = {q_src[i][lav_pkg::QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_n_r[j] <= n_src;
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j][i] <= rem_nxt[i];
          dv_q_r[j][i]   <= q_nxt[i];
        end
      end
    end
  end

  // restore the signs
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= car_r[NS-1].neg[i] ? -$signed({1'b0, dv_q_r[lav_pkg::QB-1][i]})
                                     :  $signed({1'b0, dv_q_r[lav_pkg::QB-1][i]});
      end
      side_r <= car_r[NS-1].side;
    end
  end

  assign out_valid = out_v_r;
  assign unit_vec  = u_r;
  assign side_out  = side_r;

endmodule

>>> rtl/core/lav_cross.sv
// ----------------------------------------------------------------------------
// lav_cross: two-stage cross product
// A unit vector crossed with a word vector: products, then differences.
// ----------------------------------------------------------------------------
module lav_cross (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  lav_pkg::unit_t [2:0]    a,
  input  lav_pkg::word_t [2:0]    b,
  input  lav_pkg::side_t          side_in,
  output logic                    out_valid,
  output lav_pkg::wide_t [2:0]    c,
  output lav_pkg::side_t          side_out
);

  localparam int PW = lav_pkg::UW + lav_pkg::DW;

  logic signed [PW-1:0] p_r [6];
  lav_pkg::side_t       p_side_r;
  logic                 p_v_r;
  lav_pkg::wide_t [2:0] c_r;
  lav_pkg::side_t       c_side_r;
  logic                 c_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= in_valid;
      c_v_r <= p_v_r;
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0]   <= $signed(a[1]) * $signed(b[2]);
      p_r[1]   <= $signed(a[2]) * $signed(b[1]);
      p_r[2]   <= $signed(a[2]) * $signed(b[0]);
      p_r[3]   <= $signed(a[0]) * $signed(b[2]);
      p_r[4]   <= $signed(a[0]) * $signed(b[1]);
      p_r[5]   <= $signed(a[1]) * $signed(b[0]);
      p_side_r <= side_in;
    end
  end

  // differences
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= lav_pkg::CW'(p_r[2*i]) - lav_pkg::CW'(p_r[2*i+1]);
      end
      c_side_r <= p_side_r;
    end
  end

  assign out_valid = c_v_r;
  assign c         = c_r;
  assign side_out  = c_side_r;

endmodule

>>> rtl/core/lav_tail.sv
// ----------------------------------------------------------------------------
// lav_tail: camera up scaling, eye dot products and output register
// Shifts the camera up vector, forms the three translations and saturates
// every field of the matrix.
// ----------------------------------------------------------------------------
module lav_tail (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  lav_pkg::wide_t [2:0]    c,
  input  lav_pkg::side_t          side_in,
  output logic                    out_valid,
  output lav_pkg::word_t [11:0]   m
);

  localparam int RW = lav_pkg::UW + lav_pkg::DW;
  localparam int UPW = lav_pkg::CU_W + lav_pkg::DW;

  logic signed [lav_pkg::CU_W-1:0]  t1_cu_r [3];
  lav_pkg::side_t                   t1_side_r;
  logic                             t1_v_r;

  logic signed [RW-1:0]             t2_pr_r [3];
  logic signed [UPW-1:0]            t2_pu_r [3];
  logic signed [RW-1:0]             t2_pf_r [3];
  logic signed [lav_pkg::CU_W-1:0]  t2_cu_r [3];
  lav_pkg::side_t                   t2_side_r;
  logic                             t2_v_r;

  logic signed [lav_pkg::DOT_W-1:0] t3_sr_r;
  logic signed [lav_pkg::DOT_W-1:0] t3_su_r;
  logic signed [lav_pkg::DOT_W-1:0] t3_sf_r;
  logic signed [lav_pkg::CU_W-1:0]  t3_cu_r [3];
  lav_pkg::side_t                   t3_side_r;
  logic                             t3_v_r;

  lav_pkg::word_t [11:0]            m_r;
  logic                             m_v_r;

  logic signed [lav_pkg::SAT_W-1:0] tr_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      t3_v_r <= 1'b0;
      m_v_r  <= 1'b0;
    end else if (adv) begin
      t1_v_r <= in_valid;
      t2_v_r <= t1_v_r;
      t3_v_r <= t2_v_r;
      m_v_r  <= t3_v_r;
    end
  end

  // camera up, floor of the fractional shift
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t1_cu_r[i] <= lav_pkg::CU_W'($signed(c[i]) >>> lav_pkg::FRAC_BITS);
      end
      t1_side_r <= side_in;
    end
  end

  // products with the eye position
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t2_pr_r[i] <= $signed(t1_side_r.r[i]) * $signed(t1_side_r.eye[i]);
        t2_pu_r[i] <= t1_cu_r[i] * $signed(t1_side_r.eye[i]);
        t2_pf_r[i] <= $signed(t1_side_r.f[i]) * $signed(t1_side_r.eye[i]);
      end
      t2_cu_r   <= t1_cu_r;
      t2_side_r <= t1_side_r;
    end
  end

  // dot product sums
  always_ff @(posedge clk) begin
    if (adv) begin
      t3_sr_r   <= lav_pkg::DOT_W'(t2_pr_r[0]) + lav_pkg::DOT_W'(t2_pr_r[1])
                 + lav_pkg::DOT_W'(t2_pr_r[2]);
      t3_su_r   <= lav_pkg::DOT_W'(t2_pu_r[0]) + lav_pkg::DOT_W'(t2_pu_r[1])
                 + lav_pkg::DOT_W'(t2_pu_r[2]);
      t3_sf_r   <= lav_pkg::DOT_W'(t2_pf_r[0]) + lav_pkg::DOT_W'(t2_pf_r[1])
                 + lav_pkg::DOT_W'(t2_pf_r[2]);
      t3_cu_r   <= t2_cu_r;
      t3_side_r <= t2_side_r;
    end
  end

  // translations, negated where needed and shifted toward minus infinity
  always_comb begin
    tr_nxt[0] = (-lav_pkg::SAT_W'(t3_sr_r)) >>> lav_pkg::FRAC_BITS;
    tr_nxt[1] = (-lav_pkg::SAT_W'(t3_su_r)) >>> lav_pkg::FRAC_BITS;
    tr_nxt[2] = lav_pkg::SAT_W'(t3_sf_r) >>> lav_pkg::FRAC_BITS;
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i]     <= lav_pkg::sat_word(lav_pkg::SAT_W'($signed(t3_side_r.r[i])));
        m_r[4 + i] <= lav_pkg::sat_word(lav_pkg::SAT_W'(t3_cu_r[i]));
        m_r[8 + i] <= lav_pkg::sat_word(-lav_pkg::SAT_W'($signed(t3_side_r.f[i])));
      end
      m_r[3]  <= lav_pkg::sat_word(tr_nxt[0]);
      m_r[7]  <= lav_pkg::sat_word(tr_nxt[1]);
      m_r[11] <= lav_pkg::sat_word(tr_nxt[2]);
    end
  end

  assign out_valid = m_v_r;
  assign m         = m_r;

endmodule

>>> rtl/core/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix: right-handed camera view matrix, top three rows
// Most of the pipeline lies in the two normalizers (one square root bit and
// one quotient bit per stage).
// Throughput: one item per cycle; the whole pipeline holds while a finished
// result waits and out_tready is low.
// Reset: synchronous rst_n clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
  output logic [383:0] out_tdata
);

  logic                  adv;
  lav_pkg::wide_t [2:0]  d_r;
  lav_pkg::side_t        d_side_r;
  logic                  d_v_r;

  logic                  n1_v;
  lav_pkg::unit_t [2:0]  n1_u;
  lav_pkg::side_t        n1_side;
  lav_pkg::side_t        c1_side_in;

  logic                  c1_v;
  lav_pkg::wide_t [2:0]  c1_c;
  lav_pkg::side_t        c1_side;

  logic                  n2_v;
  lav_pkg::unit_t [2:0]  n2_u;
  lav_pkg::side_t        n2_side;
  lav_pkg::side_t        c2_side_in;
  lav_pkg::word_t [2:0]  f_word;

  logic                  c2_v;
  lav_pkg::wide_t [2:0]  c2_c;
  lav_pkg::side_t        c2_side;

  logic                  t_v;
  lav_pkg::word_t [11:0] t_m;

  // the pipeline moves whenever the output register is free or taken
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // view direction before normalizing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= lav_pkg::CW'($signed(in_tdata[96 + 32*i +: 32]))
                - lav_pkg::CW'($signed(in_tdata[32*i +: 32]));
        d_side_r.eye[i] <= in_tdata[32*i +: 32];
        d_side_r.up[i]  <= in_tdata[192 + 32*i +: 32];
        d_side_r.f[i]   <= '0;
        d_side_r.r[i]   <= '0;
      end
    end
  end

  lav_norm u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (d_v_r),
    .vec       (d_r),
    .side_in   (d_side_r),
    .out_valid (n1_v),
    .unit_vec  (n1_u),
    .side_out  (n1_side)
  );

  // forward joins the sideband
  always_comb begin
    c1_side_in   = n1_side;
    c1_side_in.f = n1_u;
  end

  lav_cross u_cross_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (n1_v),
    .a         (n1_u),
    .b         (n1_side.up),
    .side_in   (c1_side_in),
    .out_valid (c1_v),
    .c         (c1_c),
    .side_out  (c1_side)
  );

  lav_norm u_norm_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (c1_v),
    .vec       (c1_c),
    .side_in   (c1_side),
    .out_valid (n2_v),
    .unit_vec  (n2_u),
    .side_out  (n2_side)
  );

  // right joins the sideband, forward widened to a word
  always_comb begin
    c2_side_in   = n2_side;
    c2_side_in.r = n2_u;
    for (int i = 0; i < 3; i++) begin
      f_word[i] = lav_pkg::DW'($signed(n2_side.f[i]));
    end
  end

  lav_cross u_cross_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (n2_v),
    .a         (n2_u),
    .b         (f_word),
    .side_in   (c2_side_in),
    .out_valid (c2_v),
    .c         (c2_c),
    .side_out  (c2_side)
  );

  lav_tail u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (c2_v),
    .c         (c2_c),
    .side_in   (c2_side),
    .out_valid (t_v),
    .m         (t_m)
  );

  assign out_tvalid = t_v;
  assign out_tdata  = t_m;

endmodule

>>> dv/look_at_view_matrix_tb.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_tb: self-checking bench for the look-at view matrix
// A directed table (zero, degenerate and extreme camera setups) is followed by
// random camera setups under several idle and stall patterns. Every result
// item is checked field by field against its typed row or a fixed-point model.
// ----------------------------------------------------------------------------
module look_at_view_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1880;
  localparam int DRAIN_WAIT = 150;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    logic [287:0] setup;
    bit           typed;
    logic [383:0] matrix;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [383:0] out_tdata;

  logic [383:0] matrix_q[$];
  dir_row_t     dir_rows[$];
  bit           cur_typed;
  logic [383:0] cur_matrix;
  int           sender_idle;
  int           rcv_stall;
  int           hold_cnt;
  bit           hold_req;
  int           n_in;
  int           n_out;
  int           n_err;

  look_at_view_matrix DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // integer square root, floor
  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // unit vector in Q format, zero for a zero vector
  function automatic void unit_vec(input longint v[3], output longint u[3]);
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned t;
    longint unsigned sum;
    longint unsigned n;
    int              len;
    mx  = 0;
    sum = 0;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return;
    end
    for (t = mx; t != 0; t = t >> 1) len++;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) mag[i] = mag[i] >> (len - 30);
      else mag[i] = mag[i] << (30 - len);
      sum += mag[i] * mag[i];
    end
    n = isqrt(sum);
    if (n == 0) n = 1;
    for (int i = 0; i < 3; i++) begin
      t    = (mag[i] << lav_pkg::FRAC_BITS) / n;
      u[i] = (v[i] < 0) ? -longint'(t) : longint'(t);
    end
  endfunction

  function automatic void cross_vec(input longint a[3], input longint b[3],
                                    output longint c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic [31:0] clamp_word(input longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // expected view matrix rows for one camera setup
  function automatic logic [383:0] view_matrix(input logic [287:0] s);
    longint      eye[3], tgt[3], upv[3], d[3], f[3], c[3], r[3], cu[3];
    longint      dr, du, df;
    logic [383:0] m;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(s[32*i +: 32]));
      tgt[i] = longint'($signed(s[32*(3+i) +: 32]));
      upv[i] = longint'($signed(s[32*(6+i) +: 32]));
      d[i]   = tgt[i] - eye[i];
    end
    unit_vec(d, f);
    cross_vec(f, upv, c);
    unit_vec(c, r);
    cross_vec(r, f, c);
    for (int i = 0; i < 3; i++) cu[i] = c[i] >>> lav_pkg::FRAC_BITS;
    dr = 0;
    du = 0;
    df = 0;
    for (int i = 0; i < 3; i++) begin
      dr += r[i] * eye[i];
      du += cu[i] * eye[i];
      df += f[i] * eye[i];
      m[32*i +: 32]     = clamp_word(r[i]);
      m[32*(4+i) +: 32] = clamp_word(cu[i]);
      m[32*(8+i) +: 32] = clamp_word(-f[i]);
    end
    m[32*3 +: 32]  = clamp_word((-dr) >>> lav_pkg::FRAC_BITS);
    m[32*7 +: 32]  = clamp_word((-du) >>> lav_pkg::FRAC_BITS);
    m[32*11 +: 32] = clamp_word(df >>> lav_pkg::FRAC_BITS);
    return m;
  endfunction

  function automatic logic [287:0] setup9(input logic [31:0] ex, ey, ez,
                                          tx, ty, tz, ux, uy, uz);
    return {uz, uy, ux, tz, ty, tx, ez, ey, ex};
  endfunction

  // random coordinate of varied magnitude
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1, 2:    return $urandom;
      3:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  // random camera setup, mostly well formed, some degenerate
  function automatic logic [287:0] rand_setup();
    logic [31:0] e[3], t[3], u[3];
    longint      dd;
    int          k;
    for (int i = 0; i < 3; i++) begin
      e[i] = rand_coord();
      t[i] = rand_coord();
      u[i] = rand_coord();
    end
    case ($urandom_range(0, 19))
      0: t = e;
      1: begin
        // up along the view direction
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) begin
          dd   = longint'($signed(t[i])) - longint'($signed(e[i]));
          u[i] = clamp_word(dd / k);
        end
      end
      default: ;
    endcase
    return setup9(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
  endfunction

  // offer one item, with random idle cycles first
  task automatic send_item(input logic [287:0] s, input bit typed,
                           input logic [383:0] m);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= s;
    cur_typed  <= typed;
    cur_matrix <= m;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  // receiver ready, with a long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  // record accepted items and check results; signals are stable mid-cycle
  always @(negedge clk) begin
    logic [383:0] want;
    if (rst_n && in_tvalid && in_tready) begin
      matrix_q.push_back(cur_typed ? cur_matrix : view_matrix(in_tdata));
      n_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (matrix_q.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        n_err++;
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (out_tdata[32*i +: 32] !== want[32*i +: 32]) begin
            $error("m%0d%0d expected %0d got %0d", i / 4, i % 4,
                   $signed(want[32*i +: 32]), $signed(out_tdata[32*i +: 32]));
            n_err++;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [383:0] z;
    logic [383:0] par;
    z   = '0;
    par = '0;
    par[32*8 +: 32] = -32'sd65536;
    n_in        = 0;
    n_out       = 0;
    n_err       = 0;
    hold_cnt    = 0;
    hold_req    = 1'b0;
    sender_idle = 0;
    rcv_stall   = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cur_typed   = 1'b0;
    cur_matrix  = '0;

    // directed table: typed rows are read straight off the math
    dir_rows.push_back('{'0, 1'b1, z});
    dir_rows.push_back('{setup9(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678,
                                32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678,
                                32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000),
                         1'b1, z});
    // up parallel to forward at the origin
    dir_rows.push_back('{setup9(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0),
                         1'b1, par});
    dir_rows.push_back('{setup9(0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0),
                         1'b0, z});
    dir_rows.push_back('{setup9(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000),
                         1'b0, z});
    dir_rows.push_back('{setup9(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h0, 32'h7fff_ffff),
                         1'b0, z});
    dir_rows.push_back('{setup9(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                32'h0000_0001, 32'hffff_ffff, 32'h0),
                         1'b0, z});
    dir_rows.push_back('{setup9(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, z});
    dir_rows.push_back('{setup9(32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, z});
    dir_rows.push_back('{setup9(32'h7fff_0000, 32'h7fff_0000, 0, 0, 0, 0,
                                0, 0, 32'h7fff_ffff),
                         1'b0, z});
    dir_rows.push_back('{setup9(32'h0003_0000, 32'h0002_0000, 32'hfffc_0000,
                                32'hfffe_8000, 32'h0000_4000, 32'h0001_0000,
                                0, 32'h0001_0000, 0),
                         1'b0, z});
    dir_rows.push_back('{setup9(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                1, 1, 1),
                         1'b1, z});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].setup, dir_rows[i].typed,
                                    dir_rows[i].matrix);
    drain();

    // random phases: free flow, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle = 0;  rcv_stall = 0;  end
        1: begin sender_idle = 71; rcv_stall = 0;  end
        2: begin sender_idle = 0;  rcv_stall = 71; end
        default: begin sender_idle = 17; rcv_stall = 17; end
      endcase
      // long receiver hold while items keep coming, to back up the pipe
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < N_RANDOM / 4; n++) send_item(rand_setup(), 1'b0, z);
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d camera setups and %0d result items", n_in, n_out);
    $display("phases: directed table, free flow, idle sender, stalls, mixed");
    if (n_err == 0 && matrix_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lav_pkg.sv
rtl/core/lav_norm.sv
rtl/core/lav_cross.sv
rtl/core/lav_tail.sv
rtl/core/look_at_view_matrix.sv
dv/look_at_view_matrix_tb.sv
